/* hdl/tdpt_pkg.sv */
// tdpt_pkg: shared widths and the request/response types of the remainder unit
// used by tdpt_divider and trial_division_prime_test; no dependencies

package tdpt_pkg;

    // width of the tested integer, sign bit included
    localparam int WIDTH = 32;
    // magnitude bits of a non-negative value
    localparam int NW    = WIDTH - 1;
    // trial divisor width: holds one past the square root of the largest value
    localparam int DW    = WIDTH / 2;
    // step counter width of the remainder unit
    localparam int CW    = $clog2(NW + 1);

    // first trial divisor and its square
    localparam int FIRST_DIV = 2;
    localparam int FIRST_SQ  = 4;

    // request to the remainder unit
    typedef struct packed {
        logic          start;
        logic [NW-1:0] dividend;
        logic [DW-1:0] divisor;
    } t_div_req;

    // response from the remainder unit
    typedef struct packed {
        logic done;
        logic zero;
    } t_div_rsp;

endpackage

/* hdl/tdpt_divider.sv */
// tdpt_divider: restoring remainder unit, one dividend bit per cycle
// depends on tdpt_pkg (widths, t_div_req, t_div_rsp)

module tdpt_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdpt_pkg::t_div_req i_req,
    output tdpt_pkg::t_div_rsp o_rsp
);

    logic                      r_busy;
    logic [tdpt_pkg::CW-1:0]   r_cnt;
    logic [tdpt_pkg::NW-1:0]   r_dvd;
    logic [tdpt_pkg::DW-1:0]   r_div;
    logic [tdpt_pkg::DW-1:0]   r_rem;
    logic                      r_done;
    logic                      r_zero;

    logic [tdpt_pkg::DW:0]     rem_sh;
    logic [tdpt_pkg::DW:0]     rem_sub;
    logic [tdpt_pkg::DW-1:0]   n_rem;

    // shift in the next dividend bit and subtract the divisor when it fits
    always_comb begin
        rem_sh  = {r_rem, r_dvd[tdpt_pkg::NW-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        if (rem_sh >= {1'b0, r_div}) begin
            n_rem = rem_sub[tdpt_pkg::DW-1:0];
        end else begin
            n_rem = rem_sh[tdpt_pkg::DW-1:0];
        end
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= tdpt_pkg::CW'(tdpt_pkg::NW);
                r_dvd  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[tdpt_pkg::NW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tdpt_pkg::CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_zero <= (n_rem == '0);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = r_zero;

    // a new request never lands on a division in progress
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    // the step counter never sits at zero while busy
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("remainder unit busy with no steps left");

    // done follows the last step of a running division
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("remainder unit done without a division");

endmodule

/* hdl/trial_division_prime_test.sv */
// trial_division_prime_test: primality test by trial division over a shared
// remainder unit; depends on tdpt_pkg and tdpt_divider
//
//   channel  direction  handshake           payload
//   request  in         i_valid / o_stall   i_number   (32 bits, signed)
//   result   out        o_valid / i_stall   o_is_prime (1 bit)
//
// negative values, zero, one, two and three give o_valid the cycle after acceptance
// each trial divisor takes a bound check with the division launch, then NW steps
// of the bit-serial remainder unit, then its registered done with the update
// worst case is about 46340 trial divisors for a 32-bit prime
// one request at a time: o_stall is high from acceptance until the result is taken
// reset is synchronous, active low, and returns the block to idle

module trial_division_prime_test (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [tdpt_pkg::WIDTH-1:0] i_number,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_is_prime
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                        r_state;
    logic [tdpt_pkg::NW-1:0]       r_n;
    logic [tdpt_pkg::DW-1:0]       r_d;
    logic [tdpt_pkg::WIDTH-1:0]    r_sq;
    logic                          r_prime;

    logic [tdpt_pkg::NW-1:0]       in_mag;
    logic                          in_neg;
    logic                          past_bound;
    logic [tdpt_pkg::WIDTH-1:0]    n_sq;
    tdpt_pkg::t_div_req            div_req;
    tdpt_pkg::t_div_rsp            div_rsp;

    // split the incoming value into sign and magnitude
    assign in_neg = i_number[tdpt_pkg::WIDTH-1];
    assign in_mag = i_number[tdpt_pkg::NW-1:0];

    // divisor square past the value ends the search; next square is sq + 2d + 1
    assign past_bound = (r_sq > {1'b0, r_n});
    assign n_sq = r_sq + {{(tdpt_pkg::WIDTH - tdpt_pkg::DW - 1){1'b0}}, r_d, 1'b1};

    // launch a division for each divisor inside the bound
    assign div_req.start    = (r_state == S_CHECK) && !past_bound;
    assign div_req.dividend = r_n;
    assign div_req.divisor  = r_d;

    tdpt_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n  <= in_mag;
                        r_d  <= tdpt_pkg::DW'(tdpt_pkg::FIRST_DIV);
                        r_sq <= tdpt_pkg::WIDTH'(tdpt_pkg::FIRST_SQ);
                        if (in_neg || in_mag < tdpt_pkg::NW'(2)) begin
                            r_prime <= 1'b0;
                            r_state <= S_OUT;
                        end else if (in_mag == tdpt_pkg::NW'(2) ||
                                     in_mag == tdpt_pkg::NW'(3)) begin
                            r_prime <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (past_bound) begin
                        r_prime <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.zero) begin
                            r_prime <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_d     <= r_d + 1'b1;
                            r_sq    <= n_sq;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_is_prime = r_prime;

    // the remainder unit only answers while the sequencer waits for it
    a_rsp_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_WAIT))
        else $error("division result outside of wait state");

    // a division is only running for a divisor inside the bound
    a_wait_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> !past_bound)
        else $error("division beyond the square-root bound");

    // trial divisors start at two
    a_div_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_d >= tdpt_pkg::DW'(tdpt_pkg::FIRST_DIV)))
        else $error("trial divisor below two");

    // a negative request is answered not prime at once
    a_neg_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && in_neg) |=> (o_valid && !o_is_prime))
        else $error("negative value not rejected");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for trial_division_prime_test; it predicts each verdict itself
// and compares every result in order. It depends on tdpt_pkg and the block's RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [tdpt_pkg::WIDTH-1:0] t_number;

    // cycles with no request or result taken before the run is declared hung
    localparam int HANG_LIMIT  = 200_000;
    // quiet cycles after the last result: about two trial divisors
    localparam int TAIL_CYCLES = 2 * (tdpt_pkg::NW + 3);

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_number i_number;
    logic    o_valid;
    logic    i_stall;
    logic    o_is_prime;

    logic    due_verdicts[$];
    int      mismatch_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      quiet_cycles;

    trial_division_prime_test DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_prime (o_is_prime)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // primality by trial division from 2; bound kept as d <= n / d
    function automatic logic prime_verdict(input t_number num);
        longint unsigned n;
        longint unsigned d;
        n = 64'(num);
        if (num[tdpt_pkg::WIDTH-1]) return 1'b0;
        if (n < 2) return 1'b0;
        if (n == 2 || n == 3) return 1'b1;
        for (d = 2; d <= n / d; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one request; valid stays up across back-to-back requests
    task automatic send_number(input t_number num);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= num;
        do @(posedge i_clk); while (o_stall);
        due_verdicts.push_back(prime_verdict(num));
    endtask

    // sender holds off until every verdict is in
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (due_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stall, in-order compare
    always @(posedge i_clk) begin
        logic want;
        i_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_verdicts.size() == 0) begin
                report_mismatch($sformatf("result %b with no request outstanding", o_is_prime));
            end else begin
                want = due_verdicts.pop_front();
                if (o_is_prime !== want)
                    report_mismatch($sformatf("is_prime %b, expected %b", o_is_prime, want));
            end
        end
    end

    // hang detection
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // a negative value, zero, one and the two small primes
    task automatic test_small_cases();
        send_number(-5);
        send_number(0);
        send_number(1);
        send_number(2);
        send_number(3);
    endtask

    // field extremes and alternating bit patterns: two negatives, the rest with small factors
    task automatic test_extremes();
        send_number(32'h8000_0000);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFE);
        send_number(32'h7FFF_FFFD);
        send_number(32'h5555_5555);
        send_number(32'h2AAA_AAAA);
    endtask

    // squares of primes: the bound itself is the only divisor
    task automatic test_prime_squares();
        send_number(4);
        send_number(9);
        send_number(25);
        send_number(49);
        send_number(121);
        send_number(1009 * 1009);
    endtask

    // primes and a product of two nearby primes
    task automatic test_primes();
        send_number(5);
        send_number(7);
        send_number(97);
        send_number(65537);
        send_number(1000003);
        send_number(1009 * 1013);
    endtask

    // mostly small values so the run stays short; large ones are negative or carry small factors
    task automatic test_random(input int count);
        int      pick;
        int      k;
        t_number num;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                num = $urandom_range(4095);
            end else if (pick < 62) begin
                num = $urandom_range(1 << 20);
            end else if (pick < 72) begin
                num = $urandom | 32'h8000_0000;
            end else if (pick < 84) begin
                num = $urandom & 32'h7FFF_FFFE;
            end else if (pick < 94) begin
                k   = $urandom_range(7, 3);
                num = (($urandom & 32'h7FFF_FFFF) / k) * k;
            end else begin
                k   = $urandom_range(200, 2);
                num = k * k;
            end
            send_number(num);
            // sender holds off mid-stream once in a while
            if ($urandom_range(99) < 5) wait_until_drained();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_number       = '0;
        mismatch_count = 0;
        send_idle_pct  = 37;
        recv_stall_pct = 80;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles a little, receiver a lot
        test_small_cases();
        test_extremes();
        test_prime_squares();
        test_primes();
        test_random(25);
        wait_until_drained();

        // the other way round
        send_idle_pct  = 80;
        recv_stall_pct = 37;
        test_random(35);
        wait_until_drained();

        // full rate both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(35);
        wait_until_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hdl/tdpt_pkg.sv
hdl/tdpt_divider.sv
hdl/trial_division_prime_test.sv
tb/tb_top.sv
